>>> rtl/core/fkx_pkg.sv
// ----------------------------------------------------------------------------
// fkx_pkg
// Shared types and constants for the keyword field extractor.
// ----------------------------------------------------------------------------
package fkx_pkg;

    localparam int MAX_KEYWORD_LEN_DEF = 8;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_KEYWORD_BYTES  = 2'd0;
    localparam logic [1:0] REG_KEYWORD_LENGTH = 2'd1;
    localparam logic [1:0] REG_FIELD_SELECT   = 2'd2;
    localparam logic [1:0] REG_MAX_FIELD_LEN  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [63:0] keyword_bytes;
        logic [3:0]  keyword_length;
        logic [7:0]  field_select;
        logic [7:0]  max_field_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       found;
    } res_t;

    typedef enum logic [4:0] {
        PH_SEARCH     = 5'b00001,
        PH_SKIP_WS    = 5'b00010,
        PH_SKIP_FIELD = 5'b00100,
        PH_COPY       = 5'b01000,
        PH_DONE       = 5'b10000
    } phase_t;

endpackage

>>> rtl/core/fkx_ifs.sv
// ----------------------------------------------------------------------------
// fkx_ifs
// Valid/ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
interface fkx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface fkx_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic       found;

    modport source (output valid, output out_byte, output is_status, output found,
                    input ready);
    modport sink   (input valid, input out_byte, input is_status, input found,
                    output ready);
endinterface

>>> rtl/core/field_after_keyword_extractor.sv
// ----------------------------------------------------------------------------
// field_after_keyword_extractor
// Finds a keyword in a byte stream and returns one comma-separated field.
//
//   channel   dir   handshake          payload
//   char_in   in    valid / ready      char_byte[7:0]
//   res_out   out   valid / ready      out_byte[7:0], is_status, found
//   apb       in    psel/penable       paddr[4:0], pwdata/prdata[63:0]
//
// One character per cycle unless a result is stalled; each result passes from
// input register to result register, set by the single-pass window compare and phase update.
// Reset (rst_n, asynchronous) clears the parser; registers return to defaults.
// A stalled result holds in its register; characters that produce no result
// keep flowing past it.
// ----------------------------------------------------------------------------
module field_after_keyword_extractor #(
    parameter int MAX_KEYWORD_LEN = fkx_pkg::MAX_KEYWORD_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    fkx_char_if.sink                       char_in,
    fkx_result_if.source                   res_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fkx_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fkx_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fkx_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import fkx_pkg::*;

    cfg_t cfg;

    fkx_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fkx_parser #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .char_in (char_in),
        .res_out (res_out)
    );

endmodule

>>> rtl/core/fkx_cfg_regs.sv
// ----------------------------------------------------------------------------
// fkx_cfg_regs
// APB-style register file: keyword, keyword length, field index, length limit.
// ----------------------------------------------------------------------------
module fkx_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fkx_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fkx_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fkx_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output fkx_pkg::cfg_t                  cfg
);
    import fkx_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_KEYWORD_BYTES:  cfg_next.keyword_bytes  = pwdata;
                REG_KEYWORD_LENGTH: cfg_next.keyword_length = pwdata[3:0];
                REG_FIELD_SELECT:   cfg_next.field_select   = pwdata[7:0];
                REG_MAX_FIELD_LEN:  cfg_next.max_field_len  = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keyword_bytes  <= '0;
            cfg_reg.keyword_length <= 4'd1;
            cfg_reg.field_select   <= 8'd0;
            cfg_reg.max_field_len  <= 8'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEYWORD_BYTES:  prdata = cfg_reg.keyword_bytes;
            REG_KEYWORD_LENGTH: prdata = CFG_DATA_W'(cfg_reg.keyword_length);
            REG_FIELD_SELECT:   prdata = CFG_DATA_W'(cfg_reg.field_select);
            REG_MAX_FIELD_LEN:  prdata = CFG_DATA_W'(cfg_reg.max_field_len);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/fkx_parser.sv
// ----------------------------------------------------------------------------
// fkx_parser
// Input register, keyword window, field parser and result register.
// ----------------------------------------------------------------------------
module fkx_parser #(
    parameter int MAX_KEYWORD_LEN = fkx_pkg::MAX_KEYWORD_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fkx_pkg::cfg_t   cfg,
    fkx_char_if.sink        char_in,
    fkx_result_if.source    res_out
);
    import fkx_pkg::*;

    localparam int WIN_W = 8 * MAX_KEYWORD_LEN;
    localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 1);
    localparam int SH_W  = (WIN_W > 8) ? $clog2(WIN_W) : 1;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    logic [WIN_W-1:0] win_reg,    win_next;
    logic [LEN_W-1:0] fill_reg,   fill_next;
    phase_t           phase_reg,  phase_next;
    logic [7:0]       fcount_reg, fcount_next;
    logic [7:0]       copied_reg, copied_next;

    logic             out_valid_reg;
    res_t             out_data_reg;

    logic             has_res;
    res_t             res;
    logic             out_free;
    logic             adv;

    logic [LEN_W-1:0] eff_len;
    logic [WIN_W-1:0] shift_win;
    logic [WIN_W-1:0] recent;
    logic [SH_W-1:0]  shamt;
    logic             key_hit;
    logic [7:0]       c;
    logic             is_ws;
    logic             copy_end;

    assign c        = in_byte_reg;
    assign is_ws    = (c == CH_SPACE) || (c == CH_TAB);
    assign copy_end = (copied_reg >= cfg.max_field_len) || (c == CH_COMMA)
                      || (c == CH_CR) || (c == CH_LF);

    // clamp keyword length to 1..MAX_KEYWORD_LEN
    always_comb
    begin
        if (cfg.keyword_length == 4'd0)
            eff_len = LEN_W'(1);
        else if (cfg.keyword_length > 4'(MAX_KEYWORD_LEN))
            eff_len = LEN_W'(MAX_KEYWORD_LEN);
        else
            eff_len = LEN_W'(cfg.keyword_length);
    end

    // newest byte enters at the top of the window
    assign shift_win = (win_reg >> 8) | (WIN_W'(c) << (WIN_W - 8));
    assign shamt     = SH_W'((MAX_KEYWORD_LEN - int'(eff_len)) * 8);
    assign recent    = shift_win >> shamt;

    always_comb
    begin
        key_hit = 1'b1;
        for (int j = 0; j < MAX_KEYWORD_LEN; j++)
        begin
            if ((j < int'(eff_len)) && (recent[8*j +: 8] != cfg.keyword_bytes[8*j +: 8]))
                key_hit = 1'b0;
        end
    end

    always_comb
    begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        fcount_next = fcount_reg;
        copied_next = copied_reg;
        has_res     = 1'b0;
        res         = '0;

        if (c == CH_NUL)
        begin
            // end of string: report if not yet done, then clear
            has_res       = (phase_reg != PH_DONE);
            res.is_status = 1'b1;
            res.found     = (phase_reg == PH_COPY);
            win_next      = '0;
            fill_next     = '0;
            phase_next    = PH_SEARCH;
            fcount_next   = 8'd0;
            copied_next   = 8'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    win_next = shift_win;
                    if (fill_reg < LEN_W'(MAX_KEYWORD_LEN))
                        fill_next = fill_reg + LEN_W'(1);
                    if ((fill_next >= eff_len) && key_hit)
                    begin
                        phase_next  = PH_SKIP_WS;
                        fcount_next = 8'd0;
                        copied_next = 8'd0;
                    end
                end
                PH_SKIP_WS:
                begin
                    if (!is_ws)
                    begin
                        if (fcount_reg == cfg.field_select)
                        begin
                            has_res = 1'b1;
                            if (copy_end)
                            begin
                                phase_next    = PH_DONE;
                                res.is_status = 1'b1;
                                res.found     = 1'b1;
                            end
                            else
                            begin
                                phase_next   = PH_COPY;
                                copied_next  = copied_reg + 8'd1;
                                res.out_byte = c;
                            end
                        end
                        else if (c == CH_COMMA)
                        begin
                            fcount_next = fcount_reg + 8'd1;
                        end
                        else
                        begin
                            phase_next = PH_SKIP_FIELD;
                        end
                    end
                end
                PH_SKIP_FIELD:
                begin
                    if (c == CH_COMMA)
                    begin
                        fcount_next = fcount_reg + 8'd1;
                        phase_next  = PH_SKIP_WS;
                    end
                end
                PH_COPY:
                begin
                    has_res = 1'b1;
                    if (copy_end)
                    begin
                        phase_next    = PH_DONE;
                        res.is_status = 1'b1;
                        res.found     = 1'b1;
                    end
                    else
                    begin
                        copied_next  = copied_reg + 8'd1;
                        res.out_byte = c;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                end
            endcase
        end
    end

    // a byte with no result moves on even while the result register is stalled
    assign out_free       = !out_valid_reg || res_out.ready;
    assign adv            = in_valid_reg && (!has_res || out_free);
    assign char_in.ready  = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
            fill_reg      <= '0;
            phase_reg     <= PH_SEARCH;
            fcount_reg    <= 8'd0;
            copied_reg    <= 8'd0;
        end
        else
        begin
            if (char_in.ready)
                in_valid_reg <= char_in.valid;
            if (adv)
            begin
                win_reg    <= win_next;
                fill_reg   <= fill_next;
                phase_reg  <= phase_next;
                fcount_reg <= fcount_next;
                copied_reg <= copied_next;
            end
            if (adv && has_res)
                out_valid_reg <= 1'b1;
            else if (res_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
            in_byte_reg <= char_in.char_byte;
        if (adv && has_res)
            out_data_reg <= res;
    end

    assign res_out.valid     = out_valid_reg;
    assign res_out.out_byte  = out_data_reg.out_byte;
    assign res_out.is_status = out_data_reg.is_status;
    assign res_out.found     = out_data_reg.found;

endmodule

>>> rtl/core/fkx_checker.sv
// ----------------------------------------------------------------------------
// fkx_checker
// Port-level checks on the result stream and the register port.
// ----------------------------------------------------------------------------
module fkx_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_out_byte,
    input logic       res_is_status,
    input logic       res_found,
    input logic       pready
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_out_byte)
        && $stable(res_is_status) && $stable(res_found))
        else $error("result changed while stalled");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_is_status |-> res_out_byte == 8'd0)
        else $error("status item carries a byte");

    a_char_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_is_status |-> !res_found)
        else $error("character item flagged found");

    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_is_status |-> res_out_byte != 8'd0)
        else $error("character item is a zero byte");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind field_after_keyword_extractor fkx_checker u_fkx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_out.valid),
    .res_ready     (res_out.ready),
    .res_out_byte  (res_out.out_byte),
    .res_is_status (res_out.is_status),
    .res_found     (res_out.found),
    .pready        (pready)
);
